[hw/rtl/dedup_ack_ring_queue_core_defines.svh]
// assertion macros used by the queue controller rtl
`ifndef DEDUP_ACK_RING_QUEUE_CORE_DEFINES_SVH
`define DEDUP_ACK_RING_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define DARQ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("darq check failed");

// next-cycle implication
`define DARQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("darq check failed");

`else

`define DARQ_ASSERT_NOW(lbl, ck, rn, ante, cons)

`define DARQ_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

[hw/rtl/darq_pkg.sv]
package darq_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 64;
	localparam int PAY_BITS_DEF = 64;

	localparam int FIELD_BITS  = 64;
	localparam int OP_BITS     = 2;
	localparam int STATUS_BITS = 3;

	typedef enum logic [OP_BITS-1:0] {
		OP_ENQ  = 2'd0,
		OP_PEEK = 2'd1,
		OP_ACK  = 2'd2
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STS_OK       = 3'd0,
		STS_BAD_ARG  = 3'd1,
		STS_FULL     = 3'd2,
		STS_DUP      = 3'd3,
		STS_EMPTY    = 3'd4,
		STS_MISMATCH = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HEAD,
		S_RESP
	} state_t;

	// write and read strobes of the record memory
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

[hw/rtl/darq_ram.sv]
module darq_ram #(
	parameter int DEPTH = darq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = darq_pkg::KEY_BITS_DEF + darq_pkg::PAY_BITS_DEF
) (
	input  logic               clk,
	input  darq_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]      waddr,
	input  logic [DW-1:0]      wdata,
	input  logic [AW-1:0]      raddr,
	output logic [DW-1:0]      rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/darq_ctrl.sv]
`include "dedup_ack_ring_queue_core_defines.svh"

module darq_ctrl #(
	parameter int DEPTH    = darq_pkg::DEPTH_DEF,
	parameter int KEY_BITS = darq_pkg::KEY_BITS_DEF,
	parameter int PAY_BITS = darq_pkg::PAY_BITS_DEF,
	parameter int AW       = $clog2(DEPTH),
	parameter int CW       = $clog2(DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [darq_pkg::OP_BITS-1:0]        in_op,
	input  logic [darq_pkg::FIELD_BITS-1:0]     in_key,
	input  logic [darq_pkg::FIELD_BITS-1:0]     in_pay,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [darq_pkg::STATUS_BITS-1:0]    out_status,
	output logic [darq_pkg::FIELD_BITS-1:0]     out_key,
	output logic [darq_pkg::FIELD_BITS-1:0]     out_pay,
	output logic [CW-1:0]                       out_count,
	output darq_pkg::mem_ctl_t                  mem_ctl,
	output logic [AW-1:0]                       mem_waddr,
	output logic [PAY_BITS+KEY_BITS-1:0]        mem_wdata,
	output logic [AW-1:0]                       mem_raddr,
	input  logic [PAY_BITS+KEY_BITS-1:0]        mem_rdata
);

	// clear every byte from the first zero byte upward, after width masking
	function automatic logic [darq_pkg::FIELD_BITS-1:0] normalise(
		input logic [darq_pkg::FIELD_BITS-1:0] w,
		input int unsigned                     bits
	);
		logic [darq_pkg::FIELD_BITS-1:0] m;
		logic [darq_pkg::FIELD_BITS-1:0] r;
		logic                            keep;
		m    = '0;
		r    = '0;
		keep = 1'b1;
		for (int b = 0; b < darq_pkg::FIELD_BITS; b++) begin
			m[b] = (b < bits);
		end
		m = w & m;
		for (int i = 0; i < darq_pkg::FIELD_BITS / 8; i++) begin
			if (m[i*8 +: 8] == 8'd0) begin
				keep = 1'b0;
			end
			if (keep) begin
				r[i*8 +: 8] = m[i*8 +: 8];
			end
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	darq_pkg::state_t state_q, state_d;

	logic [AW-1:0]       head_q, tail_q, ptr_q;
	logic [CW-1:0]       count_q, issued_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PAY_BITS-1:0] pay_q;

	// result held until the output register frees up
	logic [darq_pkg::STATUS_BITS-1:0] res_status_q;
	logic [KEY_BITS-1:0]              res_key_q;
	logic [PAY_BITS-1:0]              res_pay_q;
	logic                             res_enq_q, res_deq_q;

	logic                             m_valid_q;
	logic [darq_pkg::STATUS_BITS-1:0] m_status_q;
	logic [KEY_BITS-1:0]              m_key_q;
	logic [PAY_BITS-1:0]              m_pay_q;
	logic [CW-1:0]                    m_cnt_q;

	logic [darq_pkg::FIELD_BITS-1:0] nk_full, np_full;
	logic [KEY_BITS-1:0]             nk, rd_key;
	logic [PAY_BITS-1:0]             np, rd_pay;
	logic                            accept, out_free, is_full, is_empty;
	logic                            scan_hit, scan_done;

	logic                             imm_fin, imm_scan, imm_head, imm_enq;
	logic [darq_pkg::STATUS_BITS-1:0] imm_status;

	logic                             fin, fin_enq, fin_deq, scan_start, scan_step, out_load;
	logic [darq_pkg::STATUS_BITS-1:0] fin_status;
	logic [KEY_BITS-1:0]              fin_key;
	logic [PAY_BITS-1:0]              fin_pay;
	logic [CW-1:0]                    cnt_next;

	assign nk_full  = normalise(in_key, KEY_BITS);
	assign np_full  = normalise(in_pay, PAY_BITS);
	assign nk       = nk_full[KEY_BITS-1:0];
	assign np       = np_full[PAY_BITS-1:0];
	assign rd_key   = mem_rdata[KEY_BITS-1:0];
	assign rd_pay   = mem_rdata[PAY_BITS+KEY_BITS-1:KEY_BITS];
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign out_free = !m_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign scan_hit = (rd_key == key_q);
	assign scan_done = (issued_q == count_q);

	// decode of a newly offered item
	always_comb begin
		imm_fin    = 1'b0;
		imm_scan   = 1'b0;
		imm_head   = 1'b0;
		imm_enq    = 1'b0;
		imm_status = darq_pkg::STS_OK;
		case (darq_pkg::op_t'(in_op))
			darq_pkg::OP_ENQ: begin
				if (nk == '0 || np == '0) begin
					imm_fin    = 1'b1;
					imm_status = darq_pkg::STS_BAD_ARG;
				end else if (is_full) begin
					imm_fin    = 1'b1;
					imm_status = darq_pkg::STS_FULL;
				end else if (is_empty) begin
					imm_fin = 1'b1;
					imm_enq = 1'b1;
				end else begin
					imm_scan = 1'b1;
				end
			end
			darq_pkg::OP_PEEK: begin
				if (is_empty) begin
					imm_fin    = 1'b1;
					imm_status = darq_pkg::STS_EMPTY;
				end else begin
					imm_head = 1'b1;
				end
			end
			darq_pkg::OP_ACK: begin
				if (nk == '0) begin
					imm_fin    = 1'b1;
					imm_status = darq_pkg::STS_BAD_ARG;
				end else if (is_empty) begin
					imm_fin    = 1'b1;
					imm_status = darq_pkg::STS_EMPTY;
				end else begin
					imm_head = 1'b1;
				end
			end
			default: begin
				imm_fin    = 1'b1;
				imm_status = darq_pkg::STS_BAD_ARG;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			darq_pkg::S_IDLE: begin
				if (in_valid) begin
					if (imm_scan) begin
						state_d = darq_pkg::S_SCAN;
					end else if (imm_head) begin
						state_d = darq_pkg::S_HEAD;
					end else begin
						state_d = darq_pkg::S_RESP;
					end
				end
			end
			darq_pkg::S_SCAN: begin
				if (scan_hit || scan_done) begin
					state_d = darq_pkg::S_RESP;
				end
			end
			darq_pkg::S_HEAD: begin
				state_d = darq_pkg::S_RESP;
			end
			darq_pkg::S_RESP: begin
				if (out_free) begin
					state_d = darq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = darq_pkg::S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		mem_ctl    = '0;
		mem_raddr  = head_q;
		fin        = 1'b0;
		fin_status = darq_pkg::STS_OK;
		fin_key    = '0;
		fin_pay    = '0;
		fin_enq    = 1'b0;
		fin_deq    = 1'b0;
		scan_start = 1'b0;
		scan_step  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			darq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mem_ctl.re = imm_scan || imm_head;
					scan_start = imm_scan;
					fin        = imm_fin;
					fin_status = imm_status;
					fin_enq    = imm_enq;
				end
			end
			darq_pkg::S_SCAN: begin
				// compare the word read last cycle, issue the next read
				if (scan_hit) begin
					fin        = 1'b1;
					fin_status = darq_pkg::STS_DUP;
				end else if (scan_done) begin
					fin     = 1'b1;
					fin_enq = 1'b1;
				end else begin
					mem_ctl.re = 1'b1;
					mem_raddr  = ptr_q;
					scan_step  = 1'b1;
				end
			end
			darq_pkg::S_HEAD: begin
				fin = 1'b1;
				if (op_q == darq_pkg::OP_PEEK) begin
					fin_key = rd_key;
					fin_pay = rd_pay;
				end else if (rd_key == key_q) begin
					fin_deq = 1'b1;
				end else begin
					fin_status = darq_pkg::STS_MISMATCH;
				end
			end
			darq_pkg::S_RESP: begin
				out_load   = out_free;
				mem_ctl.we = out_free && res_enq_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign mem_waddr = tail_q;
	assign mem_wdata = {pay_q, key_q};
	assign cnt_next  = count_q + CW'(res_enq_q) - CW'(res_deq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= darq_pkg::S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			issued_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (scan_start) begin
				ptr_q    <= wrap_inc(head_q);
				issued_q <= CW'(1);
			end else if (scan_step) begin
				ptr_q    <= wrap_inc(ptr_q);
				issued_q <= issued_q + 1'b1;
			end
			if (out_load) begin
				count_q <= cnt_next;
				if (res_enq_q) begin
					tail_q <= wrap_inc(tail_q);
				end
				if (res_deq_q) begin
					head_q <= wrap_inc(head_q);
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			key_q <= nk;
			pay_q <= np;
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_key_q    <= fin_key;
			res_pay_q    <= fin_pay;
			res_enq_q    <= fin_enq;
			res_deq_q    <= fin_deq;
		end
		if (out_load) begin
			m_status_q <= res_status_q;
			m_key_q    <= res_key_q;
			m_pay_q    <= res_pay_q;
			m_cnt_q    <= cnt_next;
		end
	end

	assign out_valid  = m_valid_q;
	assign out_status = m_status_q;
	assign out_key    = darq_pkg::FIELD_BITS'(m_key_q);
	assign out_pay    = darq_pkg::FIELD_BITS'(m_pay_q);
	assign out_count  = m_cnt_q;

	`DARQ_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`DARQ_ASSERT_NOW(a_ring_ptrs, clk, arst_n,
		(count_q == '0) || (count_q == CW'(DEPTH)), tail_q == head_q)
	`DARQ_ASSERT_NOW(a_scan_bound, clk, arst_n,
		state_q == darq_pkg::S_SCAN, (issued_q <= count_q) && (issued_q != '0))
	`DARQ_ASSERT_NOW(a_write_only_on_enq, clk, arst_n,
		mem_ctl.we, (state_q == darq_pkg::S_RESP) && res_enq_q && !is_full)
	`DARQ_ASSERT_NEXT(a_resp_delivers, clk, arst_n,
		(state_q == darq_pkg::S_RESP) && out_free,
		m_valid_q && (state_q == darq_pkg::S_IDLE))

endmodule

[hw/rtl/dedup_ack_ring_queue_core.sv]
// channel   dir  fields (tdata/tuser)                                 meaning
// s_*       in   tuser: opcode; tdata: event_key, payload_word        one operation per beat
// m_*       out  tuser: status; tdata: head_key, head_payload, count  one result per beat
//
// rejected items and an enqueue into an empty queue finish on accept and go straight to the response state
// peek and acknowledge read the head first, in the head state
// an enqueue into a non-empty queue that passes its checks scans the queued keys through the single
// memory read port, one per cycle, before its result is formed
// arst_n clears head, tail, count and the sequencer; the memory holds no reset
// a stalled m_tready holds the finished result; the next beat is not taken until it moves to the output register
module dedup_ack_ring_queue_core #(
	parameter int DEPTH    = darq_pkg::DEPTH_DEF,
	parameter int KEY_BITS = darq_pkg::KEY_BITS_DEF,
	parameter int PAY_BITS = darq_pkg::PAY_BITS_DEF,
	localparam int AW      = $clog2(DEPTH),
	localparam int CW      = $clog2(DEPTH + 1),
	localparam int IN_W    = 2 * darq_pkg::FIELD_BITS,
	localparam int OUT_W   = ((2 * darq_pkg::FIELD_BITS + CW + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_W-1:0]                  s_tdata,  // event_key, payload_word
	input  logic [darq_pkg::OP_BITS-1:0]     s_tuser,  // opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_W-1:0]                 m_tdata,  // head_key, head_payload, fill_count
	output logic [darq_pkg::STATUS_BITS-1:0] m_tuser   // status
);

	localparam int FB = darq_pkg::FIELD_BITS;

	darq_pkg::mem_ctl_t          mem_ctl;
	logic [AW-1:0]               mem_waddr, mem_raddr;
	logic [PAY_BITS+KEY_BITS-1:0] mem_wdata, mem_rdata;
	logic [FB-1:0]               head_key, head_payload;
	logic [CW-1:0]               fill_count;

	darq_ctrl #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS),
		.PAY_BITS (PAY_BITS),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_key     (s_tdata[FB-1:0]),
		.in_pay     (s_tdata[2*FB-1:FB]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_key    (head_key),
		.out_pay    (head_payload),
		.out_count  (fill_count),
		.mem_ctl    (mem_ctl),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	darq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (PAY_BITS + KEY_BITS)
	) u_ram (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign m_tdata = OUT_W'({fill_count, head_payload, head_key});

endmodule

[bench/dedup_ack_ring_queue_core_tb.sv]
module dedup_ack_ring_queue_core_tb;

	localparam int SLOTS = darq_pkg::DEPTH_DEF;
	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam int OUT_W = ((2 * darq_pkg::FIELD_BITS + FILL_W + 7) / 8) * 8;
	localparam int RANDOM_OPS = 430;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [darq_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		darq_pkg::status_t status;
		logic [63:0] head_key;
		logic [63:0] head_payload;
		logic [FILL_W-1:0] fill;
	} queue_answer_t;

	typedef struct {
		logic [darq_pkg::OP_BITS-1:0] op;
		logic [63:0] key;
		logic [63:0] pay;
		bit typed;
		queue_answer_t answer;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [2*darq_pkg::FIELD_BITS-1:0] s_tdata = '0;
	logic [darq_pkg::OP_BITS-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [darq_pkg::STATUS_BITS-1:0] m_tuser;

	// mirror of the record ring
	logic [63:0] model_keys [SLOTS];
	logic [63:0] model_pays [SLOTS];
	logic [3:0] model_head = '0;
	logic [FILL_W-1:0] model_count = '0;

	queue_answer_t answers_due [$];
	queue_answer_t got_answer;
	int mismatches = 0;
	int beats_sent = 0;

	dedup_ack_ring_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// a word is a string: bytes from the first zero byte up are dropped
	function automatic logic [63:0] trim_text(input logic [63:0] w);
		logic [63:0] r;
		r = '0;
		for (int b = 0; b < 8; b++) begin
			if (w[b*8 +: 8] == 8'h00)
				break;
			r[b*8 +: 8] = w[b*8 +: 8];
		end
		return r;
	endfunction

	// random garbage above the terminator, same string value
	function automatic logic [63:0] with_junk(input logic [63:0] w);
		logic [63:0] keep;
		keep = '0;
		for (int b = 0; b < 8; b++) begin
			keep[b*8 +: 8] = 8'hff;
			if (w[b*8 +: 8] == 8'h00)
				break;
		end
		return w | ({$urandom, $urandom} & ~keep);
	endfunction

	function automatic logic [63:0] random_text(input int min_len);
		logic [63:0] w;
		int len;
		w = {$urandom, $urandom};
		len = $urandom_range(8, min_len);
		for (int b = 0; b < 8; b++) begin
			if (b < len) begin
				if (w[b*8 +: 8] == 8'h00)
					w[b*8 +: 8] = 8'h5a;
			end else if (b == len || $urandom_range(1, 0) == 1) begin
				w[b*8 +: 8] = 8'h00;
			end
		end
		return w;
	endfunction

	function automatic queue_answer_t apply_queue_op(input logic [darq_pkg::OP_BITS-1:0] op,
			input logic [63:0] raw_key, input logic [63:0] raw_pay);
		queue_answer_t a;
		logic [63:0] key;
		logic [63:0] pay;
		bit seen;
		logic [3:0] slot;
		key = trim_text(raw_key);
		pay = trim_text(raw_pay);
		a.status = darq_pkg::STS_OK;
		a.head_key = '0;
		a.head_payload = '0;
		seen = 0;
		case (op)
			darq_pkg::OP_ENQ: begin
				for (int k = 0; k < SLOTS; k++) begin
					slot = model_head + 4'(k);
					if (k < model_count && model_keys[slot] == key)
						seen = 1;
				end
				if (key == '0 || pay == '0)
					a.status = darq_pkg::STS_BAD_ARG;
				else if (model_count >= SLOTS)
					a.status = darq_pkg::STS_FULL;
				else if (seen)
					a.status = darq_pkg::STS_DUP;
				else begin
					slot = model_head + model_count[3:0];
					model_keys[slot] = key;
					model_pays[slot] = pay;
					model_count = model_count + 1'b1;
				end
			end
			darq_pkg::OP_PEEK: begin
				if (model_count == '0)
					a.status = darq_pkg::STS_EMPTY;
				else begin
					a.head_key = model_keys[model_head];
					a.head_payload = model_pays[model_head];
				end
			end
			darq_pkg::OP_ACK: begin
				if (key == '0)
					a.status = darq_pkg::STS_BAD_ARG;
				else if (model_count == '0)
					a.status = darq_pkg::STS_EMPTY;
				else if (model_keys[model_head] != key)
					a.status = darq_pkg::STS_MISMATCH;
				else begin
					model_head = model_head + 1'b1;
					model_count = model_count - 1'b1;
				end
			end
			default: a.status = darq_pkg::STS_BAD_ARG;
		endcase
		a.fill = model_count;
		return a;
	endfunction

	function automatic op_row_t step_row(input logic [darq_pkg::OP_BITS-1:0] op,
			input logic [63:0] key, input logic [63:0] pay, input bit typed,
			input darq_pkg::status_t status, input int fill);
		op_row_t r;
		r.op = op;
		r.key = key;
		r.pay = pay;
		r.typed = typed;
		r.answer.status = status;
		r.answer.head_key = '0;
		r.answer.head_payload = '0;
		r.answer.fill = FILL_W'(fill);
		return r;
	endfunction

	// entered and left at a falling edge
	task automatic issue_op(input op_row_t r);
		queue_answer_t predicted;
		bit calm;
		calm = beats_sent >= 200 && beats_sent < 300;
		while (!calm && $urandom_range(99, 0) < 32) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.op;
		s_tdata <= {r.pay, r.key};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_queue_op(r.op, r.key, r.pay);
		answers_due.push_back(r.typed ? r.answer : predicted);
		beats_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				$error("result beat with nothing outstanding, status %0d", m_tuser);
				mismatches++;
			end else begin
				got_answer = answers_due.pop_front();
				if (m_tuser !== got_answer.status) begin
					$error("status: expected %0d, got %0d", got_answer.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[63:0] !== got_answer.head_key) begin
					$error("head_key: expected %h, got %h", got_answer.head_key,
						m_tdata[63:0]);
					mismatches++;
				end
				if (m_tdata[127:64] !== got_answer.head_payload) begin
					$error("head_payload: expected %h, got %h", got_answer.head_payload,
						m_tdata[127:64]);
					mismatches++;
				end
				if (m_tdata[128 +: FILL_W] !== got_answer.fill) begin
					$error("fill_count: expected %0d, got %0d", got_answer.fill,
						m_tdata[128 +: FILL_W]);
					mismatches++;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off, one stretch always ready
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n);
		for (n = 0; ; n++) begin
			@(negedge clk);
			if (n >= 800 && n < 1100)
				m_tready <= 1'b0;
			else if (n >= 100 && n < 600)
				m_tready <= 1'b1;
			else
				m_tready <= $urandom_range(99, 0) >= 32;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		op_row_t opening_ops [$];
		op_row_t r;
		logic [63:0] key_pool [12];
		int roll;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 12; i++)
			key_pool[i] = trim_text(random_text(1));

		opening_ops.push_back(step_row(darq_pkg::OP_PEEK, '0, '0, 1, darq_pkg::STS_EMPTY, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ACK, 64'h41, '0, 1,
			darq_pkg::STS_EMPTY, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ACK, '0, 64'h41, 1,
			darq_pkg::STS_BAD_ARG, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ENQ, '0, 64'h41, 1,
			darq_pkg::STS_BAD_ARG, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ENQ, 64'h41, 64'hff00, 1,
			darq_pkg::STS_BAD_ARG, 0));
		opening_ops.push_back(step_row(OP_UNUSED, 64'h41, 64'h41, 1, darq_pkg::STS_BAD_ARG, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ENQ, '1, '1, 1, darq_pkg::STS_OK, 1));
		// garbage above the terminator must be ignored
		opening_ops.push_back(step_row(darq_pkg::OP_ENQ, 64'hffff_ffff_ff00_0041,
			64'h1234_0000_0000_5a5a, 0, darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ENQ, 64'h41, 64'h7, 0, darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_PEEK, '0, '0, 0, darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ACK, 64'h42, '0, 0, darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ACK, 64'hffff_ffff_ffff_ff00, '0, 1,
			darq_pkg::STS_BAD_ARG, 2));
		opening_ops.push_back(step_row(darq_pkg::OP_ACK, '1, '0, 0, darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_PEEK, '1, '1, 0, darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ACK, 64'ha5a5_0000_0000_0041, '0, 0,
			darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_PEEK, '0, '0, 1, darq_pkg::STS_EMPTY, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ENQ, 64'h80, 64'h01, 0, darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(darq_pkg::OP_ENQ, 64'h0102_0304_0506_0708,
			64'h8070_6050_4030_2010, 0, darq_pkg::STS_OK, 0));
		opening_ops.push_back(step_row(OP_UNUSED, '1, '1, 1, darq_pkg::STS_BAD_ARG, 2));
		opening_ops.push_back(step_row(darq_pkg::OP_PEEK, '0, '0, 0, darq_pkg::STS_OK, 0));

		@(negedge clk);
		foreach (opening_ops[i])
			issue_op(opening_ops[i]);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			r = step_row(darq_pkg::OP_PEEK, {$urandom, $urandom}, {$urandom, $urandom}, 0,
				darq_pkg::STS_OK, 0);
			roll = $urandom_range(99, 0);
			if (roll < 6) begin
				// malformed requests
				case ($urandom_range(3, 0))
					0: r.op = OP_UNUSED;
					1: begin
						r.op = darq_pkg::OP_ENQ;
						r.key[7:0] = 8'h00;
					end
					2: begin
						r.op = darq_pkg::OP_ENQ;
						r.key = random_text(1);
						r.pay[7:0] = 8'h00;
					end
					default: begin
						r.op = darq_pkg::OP_ACK;
						r.key[7:0] = 8'h00;
					end
				endcase
			end else begin
				// alternate between filling the ring and draining it
				roll = $urandom_range(99, 0);
				if ((i / 50) % 2 == 0)
					r.op = roll < 80 ? darq_pkg::OP_ENQ
						: (roll < 90 ? darq_pkg::OP_PEEK : darq_pkg::OP_ACK);
				else
					r.op = roll < 20 ? darq_pkg::OP_ENQ
						: (roll < 35 ? darq_pkg::OP_PEEK : darq_pkg::OP_ACK);
				roll = $urandom_range(99, 0);
				if (r.op == darq_pkg::OP_ENQ) begin
					r.key = roll < 35 ? with_junk(key_pool[$urandom_range(11, 0)])
						: random_text(1);
					r.pay = random_text(1);
				end else if (r.op == darq_pkg::OP_ACK) begin
					if (model_count != '0 && roll < 75)
						r.key = with_junk(model_keys[model_head]);
					else if (roll < 88)
						r.key = with_junk(key_pool[$urandom_range(11, 0)]);
					else
						r.key = random_text(1);
				end
			end
			issue_op(r);
		end
		s_tvalid <= 1'b0;

		wait (answers_due.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
